/* rtl/agm_pkg.sv */
package agm_pkg;

    localparam int NumLanes = 2;

    typedef enum logic [1:0] {
        KIND_PCM   = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    // statistic indexes
    localparam logic [3:0] STAT_FRAMES         = 4'd0;
    localparam logic [3:0] STAT_STEP_MAX_L     = 4'd1;
    localparam logic [3:0] STAT_STEP_MAX_R     = 4'd2;
    localparam logic [3:0] STAT_OVER_LOW_L     = 4'd3;
    localparam logic [3:0] STAT_OVER_LOW_R     = 4'd4;
    localparam logic [3:0] STAT_OVER_HIGH_L    = 4'd5;
    localparam logic [3:0] STAT_OVER_HIGH_R    = 4'd6;
    localparam logic [3:0] STAT_ZERO_FRAMES    = 4'd7;
    localparam logic [3:0] STAT_ZERO_FRAME_RUN = 4'd8;
    localparam logic [3:0] STAT_ZERO_SAMP_L    = 4'd9;
    localparam logic [3:0] STAT_ZERO_SAMP_R    = 4'd10;
    localparam logic [3:0] STAT_ZERO_RUN_L     = 4'd11;
    localparam logic [3:0] STAT_ZERO_RUN_R     = 4'd12;
    localparam logic [3:0] STAT_CONST_RUN_L    = 4'd13;
    localparam logic [3:0] STAT_CONST_RUN_R    = 4'd14;

    // register indexes
    localparam logic REG_VOLUME   = 1'b0;
    localparam logic REG_CHANNELS = 1'b1;

    localparam logic [6:0]  VolumeFull   = 7'd100;
    localparam logic [1:0]  ChannelReset = 2'd2;
    localparam logic [16:0] StepLow      = 17'd4096;
    localparam logic [16:0] StepHigh     = 17'd8192;

    // floor(m / 100) == (m * RecipMul) >> RecipShift for every m below 2^22
    localparam logic [22:0] RecipMul   = 23'd5368710;
    localparam int          RecipShift = 29;

    typedef struct packed {
        logic [16:0] step_max;
        logic [31:0] over_low;
        logic [31:0] over_high;
        logic [31:0] zero_cnt;
        logic [31:0] zero_run_peak;
        logic [31:0] const_run_max;
    } agm_lane_stats_t;

endpackage

/* rtl/agm_scale.sv */
module agm_scale import agm_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] sample,
    input  logic        [6:0]  volume,
    output logic signed [15:0] scaled
);

    logic [15:0] mag_in;
    logic [22:0] prod_full;
    logic [21:0] mag_reg;
    logic [21:0] mag_next;
    logic        neg1_reg;
    logic [44:0] recip_full;
    logic [15:0] quot_reg;
    logic [15:0] quot_next;
    logic        neg2_reg;

    // magnitude first so the quotient truncates toward zero
    assign mag_in     = sample[15] ? 16'(-sample) : 16'(sample);
    assign prod_full  = mag_in * volume;
    assign mag_next   = prod_full[21:0];
    assign recip_full = mag_reg * RecipMul;
    assign quot_next  = recip_full[RecipShift+15:RecipShift];

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            neg1_reg <= sample[15];
            quot_reg <= quot_next;
            neg2_reg <= neg1_reg;
        end
    end

    assign scaled = neg2_reg ? 16'(-quot_reg) : quot_reg;

endmodule

/* rtl/agm_lane.sv */
module agm_lane import agm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               upd,
    input  logic               clr,
    input  logic signed [15:0] sample,
    output logic               sample_zero,
    output agm_lane_stats_t    stats
);

    logic [15:0]     prev_reg, prev_next;
    logic            prev_valid_reg, prev_valid_next;
    logic [31:0]     zero_run_reg, zero_run_next;
    logic [31:0]     const_run_reg, const_run_next;
    agm_lane_stats_t stats_reg, stats_next;

    logic signed [16:0] diff;
    logic [16:0]        adiff;
    logic [31:0]        zero_run_inc;
    logic [31:0]        const_run_new;

    assign sample_zero  = (sample == 16'sd0);
    assign diff         = {sample[15], sample} - {prev_reg[15], prev_reg};
    assign adiff        = diff[16] ? 17'(-diff) : 17'(diff);
    assign zero_run_inc = zero_run_reg + 32'd1;

    always_comb begin
        if (prev_valid_reg && adiff == 17'd0) begin
            const_run_new = const_run_reg + 32'd1;
        end else begin
            const_run_new = 32'd1;
        end
    end

    always_comb begin
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        zero_run_next   = zero_run_reg;
        const_run_next  = const_run_reg;
        stats_next      = stats_reg;
        if (clr) begin
            prev_next       = '0;
            prev_valid_next = 1'b0;
            zero_run_next   = '0;
            const_run_next  = '0;
            stats_next      = '0;
        end else if (upd) begin
            if (sample_zero) begin
                stats_next.zero_cnt = stats_reg.zero_cnt + 32'd1;
                zero_run_next       = zero_run_inc;
                if (zero_run_inc > stats_reg.zero_run_peak) begin
                    stats_next.zero_run_peak = zero_run_inc;
                end
            end else begin
                zero_run_next = '0;
            end
            // no step on the first sample after reset or clear
            if (prev_valid_reg) begin
                if (adiff > stats_reg.step_max) begin
                    stats_next.step_max = adiff;
                end
                if (adiff > StepLow) begin
                    stats_next.over_low = stats_reg.over_low + 32'd1;
                end
                if (adiff > StepHigh) begin
                    stats_next.over_high = stats_reg.over_high + 32'd1;
                end
            end
            const_run_next = const_run_new;
            if (const_run_new > stats_reg.const_run_max) begin
                stats_next.const_run_max = const_run_new;
            end
            prev_next       = sample;
            prev_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            zero_run_reg   <= '0;
            const_run_reg  <= '0;
            stats_reg      <= '0;
        end else begin
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            zero_run_reg   <= zero_run_next;
            const_run_reg  <= const_run_next;
            stats_reg      <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

/* rtl/agm_merge.sv */
module agm_merge import agm_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            frame_upd,
    input  logic            clr,
    input  logic            stereo,
    input  logic            lane_zero [NumLanes],
    input  agm_lane_stats_t lane_stats [NumLanes],
    input  logic [3:0]      stat_index,
    output logic [31:0]     stat_value
);

    logic [31:0] frames_reg, frames_next;
    logic [31:0] zero_frames_reg, zero_frames_next;
    logic [31:0] frame_run_reg, frame_run_next;
    logic [31:0] frame_run_max_reg, frame_run_max_next;
    logic [31:0] frame_run_inc;
    logic        frame_silent;

    // in mono only channel 0 decides
    assign frame_silent  = lane_zero[0] && (!stereo || lane_zero[1]);
    assign frame_run_inc = frame_run_reg + 32'd1;

    always_comb begin
        frames_next        = frames_reg;
        zero_frames_next   = zero_frames_reg;
        frame_run_next     = frame_run_reg;
        frame_run_max_next = frame_run_max_reg;
        if (clr) begin
            frames_next        = '0;
            zero_frames_next   = '0;
            frame_run_next     = '0;
            frame_run_max_next = '0;
        end else if (frame_upd) begin
            frames_next = frames_reg + 32'd1;
            if (frame_silent) begin
                zero_frames_next = zero_frames_reg + 32'd1;
                frame_run_next   = frame_run_inc;
                if (frame_run_inc > frame_run_max_reg) begin
                    frame_run_max_next = frame_run_inc;
                end
            end else begin
                frame_run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg        <= '0;
            zero_frames_reg   <= '0;
            frame_run_reg     <= '0;
            frame_run_max_reg <= '0;
        end else begin
            frames_reg        <= frames_next;
            zero_frames_reg   <= zero_frames_next;
            frame_run_reg     <= frame_run_next;
            frame_run_max_reg <= frame_run_max_next;
        end
    end

    always_comb begin
        case (stat_index)
            STAT_FRAMES:         stat_value = frames_reg;
            STAT_STEP_MAX_L:     stat_value = 32'(lane_stats[0].step_max);
            STAT_STEP_MAX_R:     stat_value = 32'(lane_stats[1].step_max);
            STAT_OVER_LOW_L:     stat_value = lane_stats[0].over_low;
            STAT_OVER_LOW_R:     stat_value = lane_stats[1].over_low;
            STAT_OVER_HIGH_L:    stat_value = lane_stats[0].over_high;
            STAT_OVER_HIGH_R:    stat_value = lane_stats[1].over_high;
            STAT_ZERO_FRAMES:    stat_value = zero_frames_reg;
            STAT_ZERO_FRAME_RUN: stat_value = frame_run_max_reg;
            STAT_ZERO_SAMP_L:    stat_value = lane_stats[0].zero_cnt;
            STAT_ZERO_SAMP_R:    stat_value = lane_stats[1].zero_cnt;
            STAT_ZERO_RUN_L:     stat_value = lane_stats[0].zero_run_peak;
            STAT_ZERO_RUN_R:     stat_value = lane_stats[1].zero_run_peak;
            STAT_CONST_RUN_L:    stat_value = lane_stats[0].const_run_max;
            STAT_CONST_RUN_R:    stat_value = lane_stats[1].const_run_max;
            default:             stat_value = '0;
        endcase
    end

endmodule

/* rtl/audio_glitch_monitor_with_volume.sv */
// Audio glitch monitor with volume. Accepts one transaction per clock while
// m_ready does not stall it: a pcm frame (kind 0), a statistic read (kind 1)
// or a clear (kind 2; kind 3 is dropped). Frames and reads produce one result,
// registered in step with the two-stage volume scaler (sample times volume,
// then a reciprocal multiply for the divide by 100) and then the output
// register; clears produce no result. Two channel lanes (the right one only in
// stereo) update their glitch statistics in the accept cycle, so a read sees
// every frame accepted before it. The whole pipeline holds while a result
// waits on m_ready. Registers: 0x0 volume in percent (low seven bits above 100
// store 100, reset 100), 0x4 channel_count (reset 2, 0 or 1 mono, 2 or 3 stereo).
module audio_glitch_monitor_with_volume import agm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [15:0] s_left_sample,
    input  logic signed [15:0] s_right_sample,
    input  logic [3:0]         s_stat_index,
    input  logic               s_last_in_chunk,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_scaled_left,
    output logic signed [15:0] m_scaled_right,
    output logic [31:0]        m_stat_value,
    output logic               m_chunk_end
);

    logic [6:0] volume_reg;
    logic [1:0] channels_reg;
    logic       cfg_wr;
    logic       stereo;

    logic       en;
    logic       in_acc;
    logic       frame_acc;
    logic       read_acc;
    logic       clr_acc;

    logic signed [15:0] lane_sample [NumLanes];
    logic               lane_zero   [NumLanes];
    agm_lane_stats_t    lane_stats  [NumLanes];
    logic signed [15:0] lane_scaled [NumLanes];
    logic [31:0]        stat_sel;

    logic        p1_valid_reg, p2_valid_reg, m_valid_reg;
    logic        p1_read_reg, p2_read_reg;
    logic        p1_chunk_reg, p2_chunk_reg;
    logic [31:0] p1_stat_reg, p2_stat_reg;
    logic signed [15:0] m_left_reg, m_right_reg;
    logic [31:0] m_stat_reg;
    logic        m_chunk_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign stereo = channels_reg[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg   <= VolumeFull;
            channels_reg <= ChannelReset;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_VOLUME: begin
                    volume_reg <= (pwdata[6:0] > VolumeFull) ? VolumeFull : pwdata[6:0];
                end
                REG_CHANNELS: begin
                    channels_reg <= pwdata[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_VOLUME:   prdata = 32'(volume_reg);
            REG_CHANNELS: prdata = 32'(channels_reg);
            default:      prdata = '0;
        endcase
    end

    // pipeline advances whenever the output register is free or drains
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign in_acc    = s_valid && s_ready;
    assign frame_acc = in_acc && (s_kind == KIND_PCM);
    assign read_acc  = in_acc && (s_kind == KIND_READ);
    assign clr_acc   = in_acc && (s_kind == KIND_CLEAR);

    assign lane_sample[0] = s_left_sample;
    assign lane_sample[1] = stereo ? s_right_sample : 16'sd0;

    for (genvar i = 0; i < NumLanes; i++) begin : g_lane
        agm_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .upd         (frame_acc && (i == 0 || stereo)),
            .clr         (clr_acc),
            .sample      (lane_sample[i]),
            .sample_zero (lane_zero[i]),
            .stats       (lane_stats[i])
        );

        agm_scale u_scale (
            .aclk   (aclk),
            .en     (en),
            .sample (lane_sample[i]),
            .volume (volume_reg),
            .scaled (lane_scaled[i])
        );
    end

    agm_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_upd  (frame_acc),
        .clr        (clr_acc),
        .stereo     (stereo),
        .lane_zero  (lane_zero),
        .lane_stats (lane_stats),
        .stat_index (s_stat_index),
        .stat_value (stat_sel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= frame_acc || read_acc;
            p2_valid_reg <= p1_valid_reg;
            m_valid_reg  <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_read_reg  <= read_acc;
            p1_chunk_reg <= read_acc ? 1'b0 : s_last_in_chunk;
            p1_stat_reg  <= read_acc ? stat_sel : 32'd0;
            p2_read_reg  <= p1_read_reg;
            p2_chunk_reg <= p1_chunk_reg;
            p2_stat_reg  <= p1_stat_reg;
            m_left_reg   <= p2_read_reg ? 16'sd0 : lane_scaled[0];
            m_right_reg  <= p2_read_reg ? 16'sd0 : lane_scaled[1];
            m_stat_reg   <= p2_stat_reg;
            m_chunk_reg  <= p2_chunk_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scaled_left  = m_left_reg;
    assign m_scaled_right = m_right_reg;
    assign m_stat_value   = m_stat_reg;
    assign m_chunk_end    = m_chunk_reg;

endmodule
